FILE: src/sdtq_pkg.sv
// Package for the sleep deadline timer queue.
// Holds command and result codes, sizes and the queue entry type. No dependencies.
package sdtq_pkg;

  localparam int CapacityDef = 16;
  localparam int MaxResults  = 16;
  localparam int TidW        = 8;
  localparam int TimeW       = 32;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REFUSED  = 2'd1,
    KIND_RELEASED = 2'd2
  } kind_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_SLEEP = 1'b1
  } cmd_t;

  // Decoded work item passed from the front part to the back part.
  typedef struct packed {
    logic            is_sleep;
    logic [TidW-1:0] tid;
    logic [TimeW-1:0] dur;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_TCHECK,
    ST_POP,
    ST_EMIT
  } bstate_t;

endpackage

FILE: src/sdtq_if.sv
// Valid/ready channel interface for the timer queue.
// Depends on nothing; the payload type is a parameter.
interface sdtq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/sdtq_front.sv
// Front part: accepts input items, decodes them and queues them for the back part.
// Depends on sdtq_pkg.
module sdtq_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [7:0]           in_thread_id,
  input  logic [31:0]          in_duration,
  output logic                 q_valid,
  input  logic                 q_pop,
  output sdtq_pkg::work_t      q_data
);
  import sdtq_pkg::*;

  // two-entry queue
  work_t      slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push;
  work_t      w;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rd_r];

  always_comb begin
    w.is_sleep = (in_command == CMD_SLEEP);
    w.tid      = in_thread_id;
    w.dur      = in_duration;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) slot_r[wr_r] <= w;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> !in_ready)
    else $error("full queue took an item");
endmodule

FILE: src/sdtq_back.sv
// Back part: keeps time and the sorted entry store, runs sleeps and ticks.
// Depends on sdtq_pkg. Store is a memory walked one entry per cycle.
module sdtq_back #(
  parameter int CAPACITY = sdtq_pkg::CapacityDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  sdtq_pkg::work_t      q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_woken_id,
  output logic                 out_last
);
  import sdtq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(MaxResults + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [39:0] mem [CAPACITY];   // {deadline, thread}
  logic [39:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [39:0] wdata;

  bstate_t st_r, st_nxt;
  logic [31:0] now_r, now_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt, pos_r, pos_nxt;
  logic [RW-1:0] nrel_r, nrel_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [7:0]  tid_r, tid_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [7:0]  oid_r, oid_nxt;
  logic        ol_r, ol_nxt;
  logic        busy_out;
  logic        due;
  logic        more;

  assign out_valid    = ov_r;
  assign out_kind     = ok_r;
  assign out_woken_id = oid_r;
  assign out_last     = ol_r;
  assign busy_out     = ov_r && !out_ready;
  assign due          = rdata_r[39:8] <= now_r;
  // another release follows when the next entry is due and the limit allows
  assign more         = (count_r > CW'(1)) && due && (nrel_r < RW'(MaxResults));

  always_comb begin
    st_nxt = st_r; now_nxt = now_r; count_nxt = count_r; idx_nxt = idx_r;
    pos_nxt = pos_r; nrel_nxt = nrel_r; dl_nxt = dl_r; tid_nxt = tid_r;
    ov_nxt = ov_r && !out_ready; ok_nxt = ok_r; oid_nxt = oid_r; ol_nxt = ol_r;
    q_pop = 1'b0; mem_we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (st_r)
      ST_IDLE: begin
        // Reads entry 0 ahead for both kinds of work.
        raddr = '0;
        if (q_valid && !busy_out) begin
          q_pop = 1'b1;
          if (q_data.is_sleep) begin
            if (count_r >= CapC) begin
              ov_nxt = 1'b1; ok_nxt = KIND_REFUSED; oid_nxt = '0; ol_nxt = 1'b1;
            end else begin
              dl_nxt = now_r + q_data.dur; tid_nxt = q_data.tid;
              idx_nxt = '0; st_nxt = ST_SEARCH;
            end
          end else begin
            now_nxt = now_r + 32'd1; nrel_nxt = '0; st_nxt = ST_TCHECK;
          end
        end
      end
      ST_SEARCH: begin
        // rdata_r holds entry idx_r
        if (idx_r < count_r && rdata_r[39:8] < dl_r) begin
          idx_nxt = idx_r + 1'b1; raddr = AW'(idx_r + 1'b1);
        end else begin
          pos_nxt = idx_r; idx_nxt = count_r;
          raddr = AW'(count_r - 1'b1);
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // Move entries back one place, from the end down to the insert point.
        if (idx_r > pos_r) begin
          mem_we = 1'b1; waddr = AW'(idx_r); wdata = rdata_r;
          idx_nxt = idx_r - 1'b1; raddr = AW'(idx_r - 2'd2);
        end else if (!busy_out) begin
          mem_we = 1'b1; waddr = AW'(pos_r); wdata = {dl_r, tid_r};
          count_nxt = count_r + 1'b1;
          ov_nxt = 1'b1; ok_nxt = KIND_ACCEPTED; oid_nxt = '0; ol_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_TCHECK: begin
        // rdata_r holds the front entry; fetch the one behind it
        raddr = '0;
        if (count_r != '0 && nrel_r < RW'(MaxResults) && due) begin
          tid_nxt = rdata_r[7:0]; nrel_nxt = nrel_r + 1'b1;
          raddr = AW'(1 % CAPACITY); st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // rdata_r holds the next entry, which decides the last flag
        raddr = AW'(1 % CAPACITY);
        if (!busy_out) begin
          ov_nxt = 1'b1; ok_nxt = KIND_RELEASED; oid_nxt = tid_r; ol_nxt = !more;
          idx_nxt = CW'(1); st_nxt = ST_POP;
        end
      end
      ST_POP: begin
        // Move entries forward one place.
        if (idx_r < count_r) begin
          mem_we = 1'b1; waddr = AW'(idx_r - 1'b1); wdata = rdata_r;
          idx_nxt = idx_r + 1'b1; raddr = AW'(idx_r + 1'b1);
          if (idx_r + 1'b1 >= count_r) raddr = '0;
        end else begin
          count_nxt = count_r - 1'b1; raddr = '0; st_nxt = ST_TCHECK;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; now_r <= '0; count_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; now_r <= now_nxt; count_r <= count_nxt; ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt; pos_r <= pos_nxt; nrel_r <= nrel_nxt; dl_r <= dl_nxt;
    tid_r <= tid_nxt; ok_r <= ok_nxt; oid_r <= oid_nxt; ol_r <= ol_nxt;
  end

  // store memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CapC)
    else $error("entry count above capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_kind, out_woken_id, out_last})))
    else $error("result dropped under stall");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> st_r == ST_IDLE)
    else $error("work taken while busy");
endmodule

FILE: src/sleep_deadline_timer_queue.sv
// Top level of the sleep deadline timer queue.
// Depends on sdtq_pkg, sdtq_if, sdtq_front and sdtq_back.
//
// Usage:
//   in channel carries command (0 tick, 1 sleep), thread_id and duration.
//   out channel carries kind, woken_id and last, one item per result.
//   A sleep gives one result: accepted, or refused when CAPACITY entries wait.
//   A tick advances time and releases every due front entry (up to 16),
//   the final one flagged last; a tick with nothing due gives no result.
// Operation:
//   Sleep runs a linear search then a shift of the store, one entry per cycle,
//   through the store memory, which has one write port and one read port.
//   Each release moves the remaining entries forward to close the gap at the front.
//   A two-item queue in front lets new items be taken while work runs.
// Reset: synchronous, active low; time and entry count clear, no sweep.
// Stall: the result register holds while out_ready is low; the back part
//   waits and the front queue fills, then in_ready drops.
module sleep_deadline_timer_queue #(
  parameter int CAPACITY = sdtq_pkg::CapacityDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_thread_id,
  input  logic [31:0] in_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_woken_id,
  output logic        out_last
);
  import sdtq_pkg::*;

  sdtq_if #(.T(work_t)) wq (.clk(clk));

  sdtq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_thread_id(in_thread_id), .in_duration(in_duration),
    .q_valid(wq.valid), .q_pop(wq.ready), .q_data(wq.data)
  );

  sdtq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(wq.valid), .q_pop(wq.ready), .q_data(wq.data),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_woken_id(out_woken_id), .out_last(out_last)
  );
endmodule

FILE: tb/sv/sleep_deadline_timer_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sleep deadline timer queue.
// Depends on sdtq_pkg, sdtq_if and the sleep_deadline_timer_queue RTL.
module sleep_deadline_timer_queue_tb;
  import sdtq_pkg::*;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 5000;
  localparam int RandItems  = 345;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  tid;
    logic [31:0] dur;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] woken;
    logic       last;
  } resp_t;

  // Timer queue model plus the store of pending responses
  class timer_scoreboard;
    logic [31:0] now_ticks;
    logic [31:0] wake_time[$];
    logic [7:0]  wake_tid[$];
    resp_t       pending[$];
    int          errors;
    int          n_released;
    int          n_refused;

    function new();
      now_ticks  = '0;
      errors     = 0;
      n_released = 0;
      n_refused  = 0;
    endfunction

    function void push_resp(kind_t k, logic [7:0] id, logic lst);
      resp_t r;
      r.kind  = k;
      r.woken = id;
      r.last  = lst;
      pending.insert(pending.size(), r);
    endfunction

    // Predict the responses of one accepted request
    function void note_request(req_t rq);
      logic [31:0] dl;
      int pos;
      int n;
      if (rq.cmd == CMD_SLEEP) begin
        if (wake_time.size() >= CapacityDef) begin
          push_resp(KIND_REFUSED, 8'd0, 1'b1);
          n_refused++;
        end else begin
          dl = now_ticks + rq.dur;
          pos = 0;
          while (pos < wake_time.size() && wake_time[pos] < dl) pos++;
          wake_time.insert(pos, dl);
          wake_tid.insert(pos, rq.tid);
          push_resp(KIND_ACCEPTED, 8'd0, 1'b1);
        end
      end else begin
        now_ticks = now_ticks + 1;
        n = 0;
        while (wake_time.size() > 0 && n < MaxResults && wake_time[0] <= now_ticks) begin
          push_resp(KIND_RELEASED, wake_tid[0], 1'b0);
          wake_time.delete(0);
          wake_tid.delete(0);
          n++;
        end
        if (n > 0) pending[pending.size() - 1].last = 1'b1;
        n_released += n;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(resp_t got);
      resp_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response kind=%0d id=%0d", got.kind, got.woken));
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.woken !== want.woken)
        report($sformatf("woken_id %0d, expected %0d", got.woken, want.woken));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  sdtq_if #(.T(req_t))  req_ch (clk);
  sdtq_if #(.T(resp_t)) resp_ch (clk);

  timer_scoreboard sb;
  bit   no_idle;
  bit   hold_req;
  int   idle_cycles;
  int   n_sent;

  sleep_deadline_timer_queue dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req_ch.valid),
    .in_ready     (req_ch.ready),
    .in_command   (req_ch.data.cmd),
    .in_thread_id (req_ch.data.tid),
    .in_duration  (req_ch.data.dur),
    .out_valid    (resp_ch.valid),
    .out_ready    (resp_ch.ready),
    .out_kind     (resp_ch.data.kind),
    .out_woken_id (resp_ch.data.woken),
    .out_last     (resp_ch.data.last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels away from the driving edge; watchdog on progress
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      if (resp_ch.valid && resp_ch.ready) sb.check_response(resp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("** sleep_deadline_timer_queue: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    resp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        resp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
        resp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        resp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken; valid stays high after
  task automatic send_req(cmd_t c, logic [7:0] id, logic [31:0] d);
    req_t rq;
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.cmd = c;
    rq.tid = id;
    rq.dur = d;
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    forever begin
      @(negedge clk);
      if (req_ch.ready) break;
    end
    @(posedge clk);
    n_sent++;
  endtask

  task automatic sleep_req(logic [7:0] id, logic [31:0] d);
    send_req(CMD_SLEEP, id, d);
  endtask

  task automatic tick();
    send_req(CMD_TICK, 8'($urandom), 32'($urandom));
  endtask

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 20);
    if (r < 85) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    return $urandom;
  endfunction

  initial begin
    int i;
    sb          = new();
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    n_sent      = 0;
    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero duration, maximum duration, extreme ids
    sleep_req(8'd0, 32'd0);
    sleep_req(8'd255, 32'hFFFF_FFFF);
    tick();
    tick();
    // Equal deadlines: newest first; fill the store, then refuse
    for (i = 0; i < CapacityDef; i++) sleep_req(i[7:0] + 8'd10, 32'd3);
    sleep_req(8'hAA, 32'd1);
    sleep_req(8'h55, 32'h8000_0000);
    // A burst of releases from one tick
    tick();
    tick();
    tick();

    // Random mix, mostly sleeps with short durations
    for (i = 0; i < RandItems; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == RandItems - 80) no_idle = 1'b1;
      if ($urandom_range(0, 99) < 55) sleep_req(8'($urandom), pick_duration());
      else tick();
    end
    // Release the entries that fall due with plain ticks
    for (i = 0; i < 30; i++) tick();
    req_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d requests: %0d threads released, %0d sleeps refused.",
             n_sent, sb.n_released, sb.n_refused);
    $display("Covered wrapped deadlines, equal deadlines, full store and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** sleep_deadline_timer_queue: PASSED **");
    else
      $display("** sleep_deadline_timer_queue: FAILED **");
    $finish;
  end

endmodule
